@@ rtl/tfm_pkg.sv @@
// Package for the topic filter matcher: character codes, register indexes,
// field widths and the item type shared by the matcher modules.
// Depends on nothing.
package tfm_pkg;

   localparam int CHAR_W     = 8;
   localparam int LENGTH_W   = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CHARS_PER_WORD = 8;

   // Special characters of a subscription filter.
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_CHARS_A = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_CHARS_B = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_CHARS_C = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_CHARS_D = 3'd4;

   // One topic character as it moves from the input register to the matcher.
   typedef struct packed {
      logic [CHAR_W-1:0] topic_char;
      logic              last_char;
   } item_type;

endpackage

@@ rtl/tfm_if.sv @@
// Handshake channels of the topic filter matcher: request (topic characters)
// and response (match flag). Depends on tfm_pkg for the field widths.
interface tfm_req_if;
   logic                      valid;
   logic                      ready;
   logic [tfm_pkg::CHAR_W-1:0] topic_char;
   logic                      last_char;

   modport source (output valid, output topic_char, output last_char, input ready);
   modport sink   (input valid, input topic_char, input last_char, output ready);
endinterface

interface tfm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, output matched, input ready);
   modport sink   (input valid, input matched, output ready);
endinterface

@@ rtl/tfm_filter_regs.sv @@
// Configuration storage for the subscription filter: length and characters,
// with the length clamped to the character capacity. Depends on tfm_pkg.
module tfm_filter_regs #(
   parameter int FILTER_CHARS = 32,
   parameter int POS_W        = $clog2(FILTER_CHARS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [tfm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tfm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output logic [tfm_pkg::CHAR_W-1:0]        filter_chars [FILTER_CHARS],
   output logic [POS_W-1:0]                  filter_len
);

   logic [tfm_pkg::LENGTH_W-1:0] length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_write_enable && csr_index == tfm_pkg::REG_FILTER_LENGTH) begin
         length_ff <= csr_write_data[tfm_pkg::LENGTH_W-1:0];
      end
   end

   // Each character slot listens to the word register that carries it.
   for (genvar k = 0; k < FILTER_CHARS; k++) begin : g_char
      localparam int WORD = k / tfm_pkg::CHARS_PER_WORD;
      localparam int LANE = k % tfm_pkg::CHARS_PER_WORD;
      localparam logic [tfm_pkg::CSR_INDEX_W-1:0] WORD_INDEX =
         tfm_pkg::REG_FILTER_CHARS_A + tfm_pkg::CSR_INDEX_W'(WORD);

      logic [tfm_pkg::CHAR_W-1:0] char_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            char_ff <= '0;
         end else if (csr_write_enable && csr_index == WORD_INDEX) begin
            char_ff <= csr_write_data[LANE*tfm_pkg::CHAR_W +: tfm_pkg::CHAR_W];
         end
      end

      assign filter_chars[k] = char_ff;
   end

   // A length beyond the capacity behaves as the full capacity.
   always_comb begin
      if (length_ff > tfm_pkg::LENGTH_W'(FILTER_CHARS)) begin
         filter_len = POS_W'(FILTER_CHARS);
      end else begin
         filter_len = POS_W'(length_ff);
      end
   end

endmodule

@@ rtl/tfm_matcher.sv @@
// Per-character matching step: filter position and phase registers and the
// logic that advances them for one topic character. Depends on tfm_pkg.
module tfm_matcher #(
   parameter int FILTER_CHARS = 32,
   parameter int POS_W        = $clog2(FILTER_CHARS + 1),
   parameter int IDX_W        = $clog2(FILTER_CHARS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  tfm_pkg::item_type           item,
   input  logic [tfm_pkg::CHAR_W-1:0]  filter_chars [FILTER_CHARS],
   input  logic [POS_W-1:0]            filter_len,
   output logic                        matched
);

   typedef enum logic [1:0] {
      PH_MATCHING,
      PH_SKIPPING,
      PH_ACCEPTED,
      PH_FAILED
   } phase_type;

   phase_type                  phase_ff, phase_in, phase_work;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [FILTER_CHARS:0]      stop;
   logic [POS_W-1:0]           search_pos, sel_pos;
   logic                       found;
   logic                       is_slash;
   logic [tfm_pkg::CHAR_W-1:0] sel_char;

   assign is_slash = (item.topic_char == tfm_pkg::CH_SLASH);

   // A slash walks over any run of '+' at once: find the first position at or
   // after the current one that is past the filter or holds no '+'.
   always_comb begin
      for (int k = 0; k < FILTER_CHARS; k++) begin
         stop[k] = (POS_W'(k) >= filter_len) || (filter_chars[k] != tfm_pkg::CH_PLUS);
      end
      stop[FILTER_CHARS] = 1'b1;
   end

   always_comb begin
      search_pos = pos_ff;
      found      = 1'b0;
      for (int k = 0; k <= FILTER_CHARS; k++) begin
         if (!found && POS_W'(k) >= pos_ff && stop[k]) begin
            search_pos = POS_W'(k);
            found      = 1'b1;
         end
      end
   end

   assign sel_pos = is_slash ? search_pos : pos_ff;

   always_comb begin
      if (sel_pos < filter_len) begin
         sel_char = filter_chars[sel_pos[IDX_W-1:0]];
      end else begin
         sel_char = '0;
      end
   end

   always_comb begin
      phase_work = phase_ff;
      if (phase_ff == PH_SKIPPING && is_slash) begin
         phase_work = PH_MATCHING;
      end
      phase_in = phase_work;
      pos_in   = pos_ff;
      if (phase_work == PH_MATCHING) begin
         if (sel_pos >= filter_len) begin
            phase_in = PH_FAILED;
         end else if (sel_char == tfm_pkg::CH_HASH) begin
            phase_in = PH_ACCEPTED;
         end else if (sel_char == tfm_pkg::CH_PLUS) begin
            pos_in   = sel_pos + POS_W'(1);
            phase_in = PH_SKIPPING;
         end else if (sel_char == item.topic_char) begin
            pos_in = sel_pos + POS_W'(1);
         end else begin
            phase_in = PH_FAILED;
         end
      end
   end

   // Flag for a last character; leftover filter characters mean no match.
   always_comb begin
      unique case (phase_in)
         PH_ACCEPTED: matched = 1'b1;
         PH_FAILED:   matched = 1'b0;
         default:     matched = (pos_in == filter_len);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MATCHING;
         pos_ff   <= '0;
      end else if (step_en) begin
         if (item.last_char) begin
            phase_ff <= PH_MATCHING;
            pos_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
         end
      end
   end

endmodule

@@ rtl/topic_filter_matcher.sv @@
// Topic filter matcher: a last character moves from the input register to the
// result register and out as its response beat. One request beat is taken every
// cycle while responses drain, set by the position/phase update in tfm_matcher.
// A synchronous active-high reset clears the filter registers to zero, empties
// both pipeline registers and returns the matcher to the start of a topic.
// Depends on tfm_pkg, tfm_if, tfm_filter_regs and tfm_matcher.
module topic_filter_matcher #(
   parameter int FILTER_CHARS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   tfm_req_if.sink                         req_if,
   tfm_rsp_if.source                       rsp_if,
   input  logic                            csr_write_enable,
   input  logic [tfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tfm_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int POS_W = $clog2(FILTER_CHARS + 1);
   localparam int IDX_W = $clog2(FILTER_CHARS);

   logic [tfm_pkg::CHAR_W-1:0] filter_chars [FILTER_CHARS];
   logic [POS_W-1:0]           filter_len;

   // Input register: holds one topic character until the matcher takes it.
   logic              in_valid_ff, in_valid_in;
   tfm_pkg::item_type in_item_ff;

   // Result register: holds one match flag until the response side takes it.
   logic rsp_valid_ff, rsp_valid_in;
   logic matched_ff;
   logic matched_step;

   logic out_free;
   logic step_en;
   logic req_take;

   tfm_filter_regs #(
      .FILTER_CHARS (FILTER_CHARS),
      .POS_W        (POS_W)
   ) u_filter_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .filter_chars     (filter_chars),
      .filter_len       (filter_len)
   );

   tfm_matcher #(
      .FILTER_CHARS (FILTER_CHARS),
      .POS_W        (POS_W),
      .IDX_W        (IDX_W)
   ) u_matcher (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .item         (in_item_ff),
      .filter_chars (filter_chars),
      .filter_len   (filter_len),
      .matched      (matched_step)
   );

   // The held character is processed whenever the result register can take a
   // new flag, that is when it is empty or its beat completes this cycle.
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign step_en  = in_valid_ff && out_free;

   // A new beat is taken whenever the input register is empty or empties this cycle, so
   // characters stream in back to back while results keep draining.
   assign req_if.ready = !in_valid_ff || step_en;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   // Only a last character produces a response beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = in_item_ff.last_char;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.topic_char <= req_if.topic_char;
         in_item_ff.last_char  <= req_if.last_char;
      end
      if (step_en && in_item_ff.last_char) begin
         matched_ff <= matched_step;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.matched = matched_ff;

endmodule
